[src/earliest_free_machine_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// earliest free machine scheduler assertion macros
// concurrent check helpers sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_MACHINE_SCHEDULER_UNIT_MACROS_SVH
`define EARLIEST_FREE_MACHINE_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication
`define EFMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EFMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/efms_pkg.sv]
// ----------------------------------------------------------------------------
// efms_pkg
// shared types and constants of the earliest free machine scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package efms_pkg;

  // machine count register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_FINISH,
    ST_SIFT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_init;
    logic do_clear;
    logic load;
    logic do_start;
    logic do_finish;
    logic do_sift;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sift_done;
  } dp_sts_t;

endpackage

`default_nettype wire

[src/efms_ctrl.sv]
// ----------------------------------------------------------------------------
// efms_ctrl
// sequencer for clearing pass, start/finish computation and heap sift-down
// ----------------------------------------------------------------------------
`default_nettype none

module efms_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 cfg_we,
  input  wire efms_pkg::dp_sts_t    sts,
  output efms_pkg::ctrl_cmd_t       cmd,
  output logic                      busy
);

  efms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= efms_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != efms_pkg::ST_IDLE);
    if (cfg_we) begin
      // new machine count restarts the clearing pass
      cmd.clr_init = 1'b1;
      state_nxt    = efms_pkg::ST_CLEAR;
    end else begin
      unique case (state_r)
        efms_pkg::ST_CLEAR: begin
          cmd.do_clear = 1'b1;
          if (sts.clr_last) begin
            state_nxt = efms_pkg::ST_IDLE;
          end
        end
        efms_pkg::ST_IDLE: begin
          if (start) begin
            cmd.load  = 1'b1;
            state_nxt = efms_pkg::ST_START;
          end
        end
        efms_pkg::ST_START: begin
          cmd.do_start = 1'b1;
          state_nxt    = efms_pkg::ST_FINISH;
        end
        efms_pkg::ST_FINISH: begin
          cmd.do_finish = 1'b1;
          state_nxt     = efms_pkg::ST_SIFT;
        end
        efms_pkg::ST_SIFT: begin
          cmd.do_sift = 1'b1;
          if (sts.sift_done) begin
            state_nxt = efms_pkg::ST_IDLE;
          end
        end
        default: begin
          state_nxt = efms_pkg::ST_CLEAR;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/efms_dpath.sv]
// ----------------------------------------------------------------------------
// efms_dpath
// heap memory, root register, time arithmetic and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module efms_dpath #(
  parameter int MAX_MACHINES = 64,
  parameter int TIME_BITS    = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire efms_pkg::ctrl_cmd_t         cmd,
  output efms_pkg::dp_sts_t                sts,
  input  wire logic [efms_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [TIME_BITS-1:0]        arrival_time,
  input  wire logic [TIME_BITS-1:0]        duration,
  output logic                             out_valid,
  output logic [TIME_BITS-1:0]             start_time,
  output logic [TIME_BITS-1:0]             finish_time,
  output logic [TIME_BITS-1:0]             makespan
);

  localparam int ADDR_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int IDX_A  = $clog2(2 * MAX_MACHINES + 1);
  localparam int IDX_W  = (IDX_A > efms_pkg::CFG_W + 1) ? IDX_A : efms_pkg::CFG_W + 1;
  localparam logic [IDX_W-1:0]  MAX_IDX   = IDX_W'(MAX_MACHINES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_MACHINES - 1);

  logic [efms_pkg::CFG_W-1:0] mc_r;
  logic [TIME_BITS-1:0]       arr_r, dur_r, start_r, finish_r, span_r, root_r;
  logic [ADDR_W-1:0]          pos_r, clr_cnt_r;
  logic                       out_valid_r;
  logic [TIME_BITS-1:0]       left_q, right_q;
  logic [TIME_BITS-1:0]       mem [MAX_MACHINES];

  logic [IDX_W-1:0]     mc_ext, cnt, pos_ext, left_c, right_c;
  logic                 take_l, take_r, sift_done;
  logic [TIME_BITS-1:0] min_val, best_val;
  logic [ADDR_W-1:0]    best_pos, rd_base;
  logic [IDX_W-1:0]     rd_base_ext, rd_l, rd_r;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] finish_sat;
  logic                 mem_we;
  logic [ADDR_W-1:0]    wa;
  logic [TIME_BITS-1:0] wd;

  always_comb begin
    mc_ext = IDX_W'(mc_r);
    if (mc_ext == '0) begin
      cnt = IDX_W'(1);
    end else if (mc_ext > MAX_IDX) begin
      cnt = MAX_IDX;
    end else begin
      cnt = mc_ext;
    end

    // children of the current sift position
    pos_ext   = IDX_W'(pos_r);
    left_c    = {pos_ext[IDX_W-2:0], 1'b1};
    right_c   = left_c + IDX_W'(1);
    take_l    = (left_c < cnt) && (left_q < finish_r);
    min_val   = take_l ? left_q : finish_r;
    take_r    = (right_c < cnt) && (right_q < min_val);
    sift_done = !take_l && !take_r;
    best_val  = take_r ? right_q : left_q;
    best_pos  = take_r ? right_c[ADDR_W-1:0] : left_c[ADDR_W-1:0];

    // next read pair
    rd_base     = cmd.do_finish ? '0 : best_pos;
    rd_base_ext = IDX_W'(rd_base);
    rd_l        = {rd_base_ext[IDX_W-2:0], 1'b1};
    rd_r        = rd_l + IDX_W'(1);

    sum        = {1'b0, start_r} + {1'b0, dur_r};
    finish_sat = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    mem_we = cmd.do_clear || (cmd.do_sift && (pos_r != '0));
    wa     = cmd.do_clear ? clr_cnt_r : pos_r;
    wd     = cmd.do_clear ? '0 : (sift_done ? finish_r : best_val);

    sts.clr_last  = (clr_cnt_r == LAST_ADDR);
    sts.sift_done = sift_done;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wa] <= wd;
    end
    left_q  <= mem[rd_l[ADDR_W-1:0]];
    right_q <= mem[rd_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r        <= efms_pkg::CFG_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.do_sift && sift_done;
      if (cmd.clr_init) begin
        mc_r      <= cfg_data;
        clr_cnt_r <= '0;
      end else if (cmd.do_clear) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_clear) begin
      root_r <= '0;
      span_r <= '0;
    end
    if (cmd.load) begin
      arr_r <= arrival_time;
      dur_r <= duration;
    end
    if (cmd.do_start) begin
      start_r <= (root_r > arr_r) ? root_r : arr_r;
    end
    if (cmd.do_finish) begin
      finish_r <= finish_sat;
      pos_r    <= '0;
    end
    if (cmd.do_sift) begin
      pos_r <= best_pos;
      if (pos_r == '0) begin
        root_r <= sift_done ? finish_r : best_val;
      end
      if (sift_done && (finish_r > span_r)) begin
        span_r <= finish_r;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign start_time  = start_r;
  assign finish_time = finish_r;
  assign makespan    = span_r;

endmodule

`default_nettype wire

[src/earliest_free_machine_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// earliest_free_machine_scheduler_unit
// list scheduler: earliest free machine from a min-heap of free-at times
// ----------------------------------------------------------------------------
// flow: an accepted item passes the start and finish states, then the sift-down
//   visits 1 to floor(log2(count)) + 1 heap levels, out_valid registered after
//   the last; no new item is taken until busy falls, and the loop of one compare
//   and one heap write per level through the dual-read memory sets the pace
// reset: busy stays high for a clearing pass over every heap entry, and again
//   after every machine count write; results cannot be stalled
`default_nettype none

`include "earliest_free_machine_scheduler_unit_macros.svh"

module earliest_free_machine_scheduler_unit #(
  parameter int MAX_MACHINES = 64,
  parameter int TIME_BITS    = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // job items
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [TIME_BITS-1:0]        in_arrival_time,
  input  wire logic [TIME_BITS-1:0]        in_duration,
  // results
  output logic                             out_valid,
  output logic [TIME_BITS-1:0]             out_start_time,
  output logic [TIME_BITS-1:0]             out_finish_time,
  output logic [TIME_BITS-1:0]             out_makespan,
  // machine count register
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [efms_pkg::CFG_W-1:0]  cfg_machine_count
);

  efms_pkg::ctrl_cmd_t cmd;
  efms_pkg::dp_sts_t   sts;
  logic                cfg_we;

  // register always writable; a write clears the schedule
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // controller: clear pass, max(arrival, root), saturated add, sift-down loop
  efms_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg_we (cfg_we),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: root held in a register, other heap entries in memory,
  // both children read per cycle, one compare and one write per heap level
  efms_dpath #(
    .MAX_MACHINES (MAX_MACHINES),
    .TIME_BITS    (TIME_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_data     (cfg_machine_count),
    .arrival_time (in_arrival_time),
    .duration     (in_duration),
    .out_valid    (out_valid),
    .start_time   (out_start_time),
    .finish_time  (out_finish_time),
    .makespan     (out_makespan)
  );

  // results only appear once the item is finished
  `EFMS_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  // an accepted item keeps the block busy
  `EFMS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item not in work")
  // finish never precedes start, saturation included
  `EFMS_ASSERT_IMP(a_finish_order, out_valid, out_finish_time >= out_start_time, "finish before start")
  // makespan covers the job just delivered
  `EFMS_ASSERT_IMP(a_span_cover, out_valid, out_makespan >= out_finish_time, "makespan below finish")

endmodule

`default_nettype wire

[tb/tb_earliest_free_machine_scheduler_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_earliest_free_machine_scheduler_unit
// self-checking bench: jobs go in through the start/busy port and every
// result is compared against an in-bench min-heap schedule of free-at times;
// runs directed corner items, then random schedules over many machine counts
// ----------------------------------------------------------------------------
module tb_earliest_free_machine_scheduler_unit;

  localparam int TB_MACHINES = 64;
  localparam int TB_TIME_W   = 48;
  localparam int RANDOM_JOBS = 1800;
  localparam logic [TB_TIME_W-1:0] TIME_MAX = '1;

  typedef logic [TB_TIME_W-1:0] time_val_t;
  typedef logic [efms_pkg::CFG_W-1:0] count_val_t;

  // one expected result item
  typedef struct packed {
    time_val_t start_time;
    time_val_t finish_time;
    time_val_t makespan;
  } job_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  time_val_t in_arrival_time = '0;
  time_val_t in_duration = '0;
  logic out_valid;
  time_val_t out_start_time;
  time_val_t out_finish_time;
  time_val_t out_makespan;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  count_val_t cfg_machine_count = '0;

  // shadow of the block: heap of free-at times, running makespan, register
  time_val_t free_at [TB_MACHINES];
  time_val_t latest_finish;
  count_val_t machine_count;

  job_result_t pending_results [$];
  int error_count = 0;
  int jobs_sent = 0;
  int results_seen = 0;
  int count_writes = 0;
  // when set, the sender pushes items back to back
  bit no_gaps = 1'b0;

  earliest_free_machine_scheduler_unit #(
    .MAX_MACHINES(TB_MACHINES),
    .TIME_BITS   (TB_TIME_W)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_arrival_time  (in_arrival_time),
    .in_duration      (in_duration),
    .out_valid        (out_valid),
    .out_start_time   (out_start_time),
    .out_finish_time  (out_finish_time),
    .out_makespan     (out_makespan),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_machine_count(cfg_machine_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // a register write wipes the whole schedule
  function automatic void clear_schedule();
    for (int i = 0; i < TB_MACHINES; i++) free_at[i] = '0;
    latest_finish = '0;
  endfunction

  // place one job on the earliest free machine and sink the new root
  function automatic job_result_t schedule_job(input time_val_t arrival,
                                               input time_val_t length);
    job_result_t res;
    logic [TB_TIME_W:0] sum;
    time_val_t held;
    int unsigned in_use;
    int unsigned pos;
    int unsigned left;
    int unsigned right;
    int unsigned best;
    bit settled;
    // zero behaves as one machine, anything past the heap size as the full heap
    if (machine_count == 0) in_use = 1;
    else if (machine_count > TB_MACHINES) in_use = TB_MACHINES;
    else in_use = 32'(machine_count);
    res.start_time = (free_at[0] < arrival) ? arrival : free_at[0];
    sum = {1'b0, res.start_time} + {1'b0, length};
    // overflow past the widest time clips to all ones
    res.finish_time = sum[TB_TIME_W] ? TIME_MAX : sum[TB_TIME_W-1:0];
    free_at[0] = res.finish_time;
    pos = 0;
    settled = 1'b0;
    while (!settled) begin
      left = 2 * pos + 1;
      right = left + 1;
      best = pos;
      // ties keep the left child, and the parent only moves on strictly less
      if (left < in_use && free_at[left] < free_at[best]) best = left;
      if (right < in_use && free_at[right] < free_at[best]) best = right;
      if (best == pos) begin
        settled = 1'b1;
      end else begin
        held = free_at[pos];
        free_at[pos] = free_at[best];
        free_at[best] = held;
        pos = best;
      end
    end
    if (res.finish_time > latest_finish) latest_finish = res.finish_time;
    res.makespan = latest_finish;
    return res;
  endfunction

  function automatic time_val_t rand_time();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TB_TIME_W-1:0];
  endfunction

  // hand one job to the block; start stays high when the next item follows at once
  task automatic send_job(input time_val_t arrival, input time_val_t length);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_arrival_time <= arrival;
    in_duration <= length;
    do @(posedge clk); while (busy);
    pending_results.push_back(schedule_job(arrival, length));
    jobs_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // machine count write, only with the block idle
  task automatic set_machine_count(input count_val_t value);
    drain_results();
    repeat ($urandom_range(0, 15)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_machine_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    machine_count = value;
    clear_schedule();
    count_writes++;
  endtask

  task automatic check_field(input string name, input time_val_t want,
                             input time_val_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // every strobe must match the oldest expectation
  always @(posedge clk) begin
    job_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h %0h %0h", $time,
                 out_start_time, out_finish_time, out_makespan);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("start_time", want.start_time, out_start_time);
        check_field("finish_time", want.finish_time, out_finish_time);
        check_field("makespan", want.makespan, out_makespan);
      end
    end
  end

  // reset state with 64 machines, field extremes and saturation
  task automatic test_reset_extremes();
    send_job('0, '0);
    send_job('0, TIME_MAX);
    send_job(TIME_MAX, '0);
    send_job(TIME_MAX, TIME_MAX);
    // sum lands exactly on the top value without clipping
    send_job({1'b0, {(TB_TIME_W-1){1'b1}}}, {1'b1, {(TB_TIME_W-1){1'b0}}});
    send_job(48'd1, TIME_MAX);
  endtask

  // out of range machine counts clamp to one machine or the full heap
  task automatic test_count_clamping();
    set_machine_count(7'd0);
    send_job(48'd5, 48'd10);
    send_job(48'd0, 48'd1);
    send_job(48'd100, 48'd0);
    set_machine_count(7'd127);
    send_job(48'd0, 48'd7);
    send_job(48'd0, 48'd7);
    send_job(48'd0, 48'd9);
    set_machine_count(7'd64);
    send_job(48'd3, 48'd4);
  endtask

  // equal free-at times force ties between children during the sink
  task automatic test_sift_ties();
    set_machine_count(7'd4);
    repeat (4) send_job(48'd0, 48'd10);
    send_job(48'd0, 48'd5);
    send_job(48'd0, 48'd5);
    send_job(48'd0, 48'd0);
  endtask

  // random jobs shaped around the current heap root
  task automatic send_random_job();
    time_val_t root;
    time_val_t arrival;
    time_val_t length;
    time_val_t delta;
    root = free_at[0];
    delta = time_val_t'($urandom_range(0, 60));
    // short jobs, sometimes a fixed length so free-at times collide
    length = ($urandom_range(0, 3) == 0) ? 48'd16 : time_val_t'($urandom_range(0, 40));
    case ($urandom_range(0, 19))
      0: arrival = rand_time();
      1: begin
        arrival = rand_time();
        length = rand_time();
      end
      2, 3: begin
        arrival = (root > TIME_MAX - delta) ? TIME_MAX : root + delta;
        length = rand_time() >> $urandom_range(8, 47);
      end
      4, 5, 6: arrival = (root > TIME_MAX - delta) ? TIME_MAX : root + delta;
      7: begin
        arrival = latest_finish;
        length = '0;
      end
      default: arrival = (root > delta) ? root - delta : '0;
    endcase
    send_job(arrival, length);
  endtask

  // random schedules over a sweep of machine counts, extremes included
  task automatic test_random_schedule();
    count_val_t counts [14];
    int per_phase;
    counts = '{7'd64, 7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd13, 7'd33, 7'd63, 7'd64,
               7'd0, 7'd127, 7'd1, 7'd65};
    counts[12] = count_val_t'($urandom_range(1, 64));
    counts[13] = count_val_t'($urandom_range(65, 127));
    per_phase = RANDOM_JOBS / 14;
    foreach (counts[p]) begin
      set_machine_count(counts[p]);
      for (int n = 0; n < per_phase; n++) begin
        if (n % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        send_random_job();
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    machine_count = efms_pkg::CFG_RESET;
    clear_schedule();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_extremes();
    test_count_clamping();
    test_sift_ties();
    test_random_schedule();
    drain_results();
    // room for a stray strobe after the last expected one
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("summary: %0d jobs sent, %0d results checked, %0d errors", jobs_sent,
             results_seen, error_count);
    $display("summary: %0d machine count writes, counts 0 through 127 incl. clamping",
             count_writes);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog well past the slowest legal run
  initial begin
    #3000000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
    $display("tb: failure");
    $finish;
  end

endmodule
